### hw/rtl/wcas_pkg.sv
// Shared types, constants and cosine table builder for the windowed cosine atom synthesiser.
`default_nettype none
package wcas_pkg;

  // Atom length limits and index width
  localparam int unsigned IDX_W   = 17;
  localparam logic [IDX_W-1:0] MAX_LEN = 17'd65536;

  // Quarter-wave cosine table geometry
  localparam int unsigned D_BITS      = 10;
  localparam int unsigned COS_DEPTH   = 1 << D_BITS;
  localparam int unsigned P_BITS      = D_BITS + 2;
  localparam int unsigned PHASE_SHIFT = 32 - P_BITS;

  // Fixed-point constants
  localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;
  localparam logic [32:0] PHASE_ROUND   = 33'(64'd1 << (PHASE_SHIFT - 1));
  localparam int unsigned PROD_SHIFT    = 30;
  localparam logic [50:0] ROUND_BIAS    = 51'(64'd1 << (PROD_SHIFT - 1));
  localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;

  typedef struct packed {
    logic        [15:0]      window_sample;
    logic signed [15:0]      amplitude;
    logic        [IDX_W-1:0] atom_len;
    logic                    first_of_channel;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] wave_sample;
    logic               last_of_channel;
  } out_item_t;

  typedef logic [15:0] cos_rom_t [COS_DEPTH];

  // Evaluate one table entry by the truncated Taylor series in Q30
  function automatic logic [15:0] cos_entry(input logic [63:0] k);
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    theta = (k * HALF_PI_Q30) / COS_DEPTH;
    t2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = 64'sd1 <<< 30;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = ($unsigned(sum) + (64'd1 << 14)) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[15:0];
  endfunction

  // Build the whole quarter-wave table at elaboration
  function automatic cos_rom_t build_cos_table();
    cos_rom_t t;
    for (int k = 0; k < COS_DEPTH; k++) begin
      t[k] = cos_entry(64'(k));
    end
    return t;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/windowed_cosine_atom_synth_core.sv
// Top level: windowed cosine atom synthesiser around one shared multiplier.
// Flow: one item at a time, taken in S_IDLE, then S_PHASE (first-of-channel only), S_LOOKUP,
//   S_MULT, S_ROUND; the result is registered once the output is free. The single multiplier
//   serves the phase start, window*amplitude and the cosine product in turn.
// Reset (synchronous): freq_step 0, phase 0, index 0, latched length 1, output empty.
// The cosine ROM is constant and needs no clearing pass.
`default_nettype none
module windowed_cosine_atom_synth_core (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire wcas_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output wcas_pkg::out_item_t      out_data,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [31:0]              cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_LOOKUP,
    S_MULT,
    S_ROUND
  } state_t;

  localparam wcas_pkg::cos_rom_t COS_ROM = wcas_pkg::build_cos_table();

  state_t                            state;
  logic [31:0]                       freq_step;
  logic [31:0]                       phase_acc;
  logic [wcas_pkg::IDX_W-1:0]        sample_index;
  logic [wcas_pkg::IDX_W-1:0]        latched_len;
  logic [15:0]                       win;
  logic signed [15:0]                amp;
  logic signed [32:0]                wa;
  logic signed [49:0]                prod;
  logic                              cos_neg;
  logic                              cos_zero;
  logic [15:0]                       cos_mag;

  logic signed [33:0]                mul_a;
  logic signed [17:0]                mul_b;
  logic signed [51:0]                mul_p;
  logic [32:0]                       p_sum;
  logic [wcas_pkg::P_BITS-1:0]       p_idx;
  logic [1:0]                        quad;
  logic [wcas_pkg::D_BITS-1:0]       r_idx;
  logic [wcas_pkg::D_BITS-1:0]       rom_addr;
  logic signed [16:0]                cos_val;
  logic [wcas_pkg::IDX_W-1:0]        len_clamped;
  logic signed [50:0]                rnd;
  logic signed [20:0]                y;
  logic signed [15:0]                y_sat;
  logic                              out_free;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // Clamp the incoming length to [1, MAX_LEN]
  always_comb begin
    len_clamped = in_data.atom_len;
    if (in_data.atom_len == '0) begin
      len_clamped = wcas_pkg::IDX_W'(1);
    end else if (in_data.atom_len > wcas_pkg::MAX_LEN) begin
      len_clamped = wcas_pkg::MAX_LEN;
    end
  end

  // Split the rounded phase into quadrant and table offset
  assign p_sum    = {1'b0, phase_acc} + wcas_pkg::PHASE_ROUND;
  assign p_idx    = p_sum[31:wcas_pkg::PHASE_SHIFT];
  assign quad     = p_idx[wcas_pkg::P_BITS-1 -: 2];
  assign r_idx    = p_idx[wcas_pkg::D_BITS-1:0];
  assign rom_addr = quad[0] ? (wcas_pkg::D_BITS'(0) - r_idx) : r_idx;

  // Read the cosine ROM
  always_ff @(posedge clk) begin
    cos_mag <= COS_ROM[rom_addr];
  end

  // Signed cosine from magnitude and quadrant flags
  always_comb begin
    if (cos_zero) begin
      cos_val = '0;
    end else if (cos_neg) begin
      cos_val = -$signed({1'b0, cos_mag});
    end else begin
      cos_val = $signed({1'b0, cos_mag});
    end
  end

  // Steer the shared multiplier operands by step
  always_comb begin
    unique case (state)
      S_PHASE: begin
        mul_a = $signed({2'b00, freq_step});
        mul_b = $signed({1'b0, latched_len} + 18'd2);
      end
      S_LOOKUP: begin
        mul_a = $signed({18'd0, win});
        mul_b = 18'(amp);
      end
      S_MULT: begin
        mul_a = 34'(wa);
        mul_b = 18'(cos_val);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round half up and saturate to Q1.15
  assign rnd = 51'(prod) + $signed(wcas_pkg::ROUND_BIAS);
  assign y   = rnd[50:wcas_pkg::PROD_SHIFT];
  always_comb begin
    if (y > 21'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y < -21'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y[15:0];
    end
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      freq_step    <= '0;
      phase_acc    <= '0;
      sample_index <= '0;
      latched_len  <= wcas_pkg::IDX_W'(1);
      out_valid    <= 1'b0;
    end else begin
      // Take a configuration write
      if (cfg_valid && cfg_ready) begin
        freq_step <= cfg_data;
      end
      // Drop the result once taken, unless a new one replaces it
      if (out_valid && !out_stall && state != S_ROUND) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            win <= in_data.window_sample;
            amp <= in_data.amplitude;
            if (in_data.first_of_channel) begin
              latched_len  <= len_clamped;
              sample_index <= '0;
              state        <= S_PHASE;
            end else begin
              state <= S_LOOKUP;
            end
          end
        end
        S_PHASE: begin
          phase_acc <= mul_p[33:2] + wcas_pkg::PHASE_QUARTER;
          state     <= S_LOOKUP;
        end
        S_LOOKUP: begin
          wa       <= mul_p[32:0];
          cos_neg  <= quad[1] ^ quad[0];
          cos_zero <= quad[0] && (r_idx == '0);
          state    <= S_MULT;
        end
        S_MULT: begin
          prod  <= mul_p[49:0];
          state <= S_ROUND;
        end
        S_ROUND: begin
          // Hold until the output register is free
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.wave_sample     <= y_sat;
            out_data.last_of_channel <= (sample_index == latched_len - wcas_pkg::IDX_W'(1));
            sample_index             <= sample_index + wcas_pkg::IDX_W'(1);
            phase_acc                <= phase_acc + freq_step;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/wcas_checker.sv
// Port-level checker for the windowed cosine atom synthesiser, bound to the top level.
`default_nettype none
module wcas_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      in_valid,
  input wire                      in_stall,
  input wire wcas_pkg::in_item_t  in_data,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire wcas_pkg::out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output item changed or vanished");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed or vanished");

  // An accepted item makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // A new result only follows busy work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  // No result the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind windowed_cosine_atom_synth_core wcas_checker u_wcas_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
